/* design/tocc_pkg.sv */
// Shared types and constants for the token occurrence counter.
`default_nettype none

package tocc_pkg;

    localparam int WIN_DEPTH   = 16;
    localparam int WIN_IDX_W   = 4;
    localparam int FILL_W      = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [15:0] LINE_MAX  = 16'hFFFF;
    localparam logic [39:0] GRAND_MAX = 40'hFF_FFFF_FFFF;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    typedef enum logic [1:0] {
        CFG_TOKEN_LOW  = 2'd0,
        CFG_TOKEN_HIGH = 2'd1,
        CFG_TOKEN_LEN  = 2'd2,
        CFG_SPACE_MODE = 2'd3
    } cfg_index_t;

    // Settled configuration as seen by the scan engine.
    typedef struct packed {
        logic [127:0]      body;
        logic [FILL_W-1:0] len;
        logic              space_mode;
    } cfg_t;

    // One classified text byte between front and back.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
        logic       is_ws;
    } q_entry_t;

endpackage

`default_nettype wire

/* design/tocc_text_if.sv */
// Text byte channel.
`default_nettype none

interface tocc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

/* design/tocc_result_if.sv */
// Result channel carrying per-text and running counts.
`default_nettype none

interface tocc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] text_count;
    logic [39:0] running_total;

    modport source (output valid, output text_count, output running_total, input ready);
    modport sink   (input valid, input text_count, input running_total, output ready);
endinterface

`default_nettype wire

/* design/tocc_cfg_if.sv */
// Configuration write channel.
`default_nettype none

interface tocc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/token_occurrence_counter_core.sv */
// Top level of the token occurrence counter: configuration registers, front and back.
// Flow: a byte enters the queue at its accepting edge and is loaded into the window once the
//   back end is idle; ST_SCAN then runs the scan steps (skip, whitespace drop, compare) and
//   returns to idle. End of text adds a publish step in ST_EMIT; the result then holds until
//   taken. A new byte leaves the queue only after the scan steps of the last one.
// Reset empties queue and window, clears tallies and result valid, restores configuration.
`default_nettype none

module token_occurrence_counter_core #(
    parameter int TOKEN_MAX = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tocc_text_if.sink     text,
    tocc_result_if.source result,
    tocc_cfg_if.sink      cfg
);
    import tocc_pkg::*;

    localparam int LEN_LIMIT = (TOKEN_MAX < WIN_DEPTH) ? TOKEN_MAX : WIN_DEPTH;
    localparam logic [FILL_W-1:0] LEN_LIMIT_L = FILL_W'(LEN_LIMIT);

    logic [63:0]       low_reg, low_next;
    logic [63:0]       high_reg, high_next;
    logic [FILL_W-1:0] len_reg, len_next;
    logic              sm_reg, sm_next;
    logic [FILL_W-1:0] raw_len;
    logic              wr;
    cfg_t              cfg_cur;
    logic              q_valid;
    q_entry_t          q_item;
    logic              q_pop;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;
    assign raw_len   = cfg.data[FILL_W-1:0];

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        len_next  = len_reg;
        sm_next   = sm_reg;
        if (wr)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_TOKEN_LOW:  low_next  = cfg.data;
                CFG_TOKEN_HIGH: high_next = cfg.data;
                CFG_TOKEN_LEN:
                begin
                    // Store the clamped body length.
                    if (raw_len == '0)
                    begin
                        len_next = FILL_W'(1);
                    end
                    else if (raw_len > LEN_LIMIT_L)
                    begin
                        len_next = LEN_LIMIT_L;
                    end
                    else
                    begin
                        len_next = raw_len;
                    end
                end
                CFG_SPACE_MODE: sm_next = cfg.data[0];
                default:        low_next = low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            len_reg  <= FILL_W'(1);
            sm_reg   <= 1'b0;
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
            len_reg  <= len_next;
            sm_reg   <= sm_next;
        end
    end

    assign cfg_cur = '{body: {high_reg, low_reg}, len: len_reg, space_mode: sm_reg};

    tocc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    tocc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_cur),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

/* design/tocc_front.sv */
// Front end: accepts text bytes, marks whitespace, queues them for the scan engine.
`default_nettype none

module tocc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tocc_text_if.sink          text,
    output logic               q_valid,
    output tocc_pkg::q_entry_t q_item,
    input  wire logic          q_pop
);
    import tocc_pkg::*;

    q_entry_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    logic               ws;

    // Hold the request off while the queue is full.
    assign text.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = text.valid && text.ready;
    assign ws         = (text.text_byte == CHAR_SPACE) || (text.text_byte == CHAR_TAB) ||
                        (text.text_byte == CHAR_NL);

    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{text_byte: text.text_byte, last: text.end_of_text,
                                     is_ws: ws};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/tocc_back.sv */
// Back end: window scan engine, tallies and result register.
`default_nettype none

module tocc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tocc_pkg::cfg_t     cfg,
    input  wire logic               q_valid,
    input  wire tocc_pkg::q_entry_t q_item,
    output logic                    q_pop,
    tocc_result_if.source           result
);
    import tocc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [7:0]        win_reg [WIN_DEPTH];
    logic [7:0]        win_next [WIN_DEPTH];
    logic [7:0]        win_sh [WIN_DEPTH];
    logic              wsw_reg [WIN_DEPTH];
    logic              wsw_next [WIN_DEPTH];
    logic              wsw_sh [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] skip_reg, skip_next;
    logic              began_reg, began_next;
    logic              last_reg, last_next;
    logic [15:0]       line_reg, line_next;
    logic [39:0]       grand_reg, grand_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       out_count_reg;
    logic [39:0]       out_total_reg;
    logic              match;
    logic              do_drop;
    logic              emit;

    assign result.valid         = out_valid_reg;
    assign result.text_count    = out_count_reg;
    assign result.running_total = out_total_reg;

    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign emit  = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH - 1; i++)
        begin
            win_sh[i] = win_reg[i + 1];
            wsw_sh[i] = wsw_reg[i + 1];
        end
        win_sh[WIN_DEPTH - 1] = '0;
        wsw_sh[WIN_DEPTH - 1] = 1'b0;
    end

    // Masked parallel compare of the window against the token body.
    always_comb
    begin
        match = 1'b1;
        for (int k = 0; k < WIN_DEPTH; k++)
        begin
            if ((FILL_W'(k) < cfg.len) && (win_reg[k] != cfg.body[8 * k +: 8]))
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        wsw_next       = wsw_reg;
        fill_next      = fill_reg;
        skip_next      = skip_reg;
        began_next     = began_reg;
        last_next      = last_reg;
        line_next      = line_reg;
        grand_next     = grand_reg;
        out_valid_next = out_valid_reg && !result.ready;
        do_drop        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    last_next  = q_item.last;
                    state_next = ST_SCAN;
                    if (fill_reg == FILL_W'(WIN_DEPTH))
                    begin
                        win_next = win_sh;
                        wsw_next = wsw_sh;
                        win_next[WIN_DEPTH - 1] = q_item.text_byte;
                        wsw_next[WIN_DEPTH - 1] = q_item.is_ws;
                    end
                    else
                    begin
                        win_next[fill_reg[WIN_IDX_W-1:0]] = q_item.text_byte;
                        wsw_next[fill_reg[WIN_IDX_W-1:0]] = q_item.is_ws;
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (fill_reg == '0)
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else if (skip_reg != '0)
                begin
                    do_drop   = 1'b1;
                    skip_next = skip_reg - 1'b1;
                end
                else if (cfg.space_mode && wsw_reg[0])
                begin
                    do_drop    = 1'b1;
                    began_next = 1'b1;
                end
                else if (fill_reg < cfg.len)
                begin
                    // Short candidate: wait for more bytes, or drop it at end of text.
                    if (last_reg)
                    begin
                        do_drop    = 1'b1;
                        began_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (match)
                begin
                    if (!cfg.space_mode || began_reg)
                    begin
                        if (line_reg != LINE_MAX)
                        begin
                            line_next = line_reg + 1'b1;
                        end
                        if (grand_reg != GRAND_MAX)
                        begin
                            grand_next = grand_reg + 1'b1;
                        end
                    end
                    skip_next  = cfg.len;
                    began_next = 1'b0;
                end
                else
                begin
                    do_drop    = 1'b1;
                    began_next = 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    fill_next      = '0;
                    skip_next      = '0;
                    began_next     = 1'b0;
                    line_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_drop)
        begin
            win_next  = win_sh;
            wsw_next  = wsw_sh;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        wsw_reg <= wsw_next;
        if (emit)
        begin
            out_count_reg <= line_reg;
            out_total_reg <= grand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            skip_reg      <= '0;
            began_reg     <= 1'b0;
            last_reg      <= 1'b0;
            line_reg      <= '0;
            grand_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            skip_reg      <= skip_next;
            began_reg     <= began_next;
            last_reg      <= last_next;
            line_reg      <= line_next;
            grand_reg     <= grand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WIN_DEPTH))
        else $error("window fill exceeds depth");

    a_grand_covers_line: assert property (@(posedge clk) disable iff (!rst_n)
        grand_reg >= {24'd0, line_reg})
        else $error("running total below text count");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && (line_reg == '0) && (fill_reg == '0) &&
                  (skip_reg == '0)))
        else $error("end of text did not publish and clear");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_SCAN))
        else $error("popped byte not scanned");

endmodule

`default_nettype wire
